/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file spfs_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define SPFS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds across reset
`define SPFS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* rtl/core/spfs_pkg.sv */
// ----------------------------------------------------------------------------
// spfs_pkg
// Levels, action codes and sideband bit positions of the priority scheduler.
// ----------------------------------------------------------------------------
package spfs_pkg;

  // number of priority levels
  localparam int LEVELS = 3;

  // level codes
  localparam logic [1:0] LVL_HIGH   = 2'd0;
  localparam logic [1:0] LVL_NORMAL = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  // action codes
  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_PICK   = 1'b1;

  // input sideband: action, priority_req
  localparam int IN_USER_W   = 3;
  localparam int IU_ACTION   = 0;
  localparam int IU_LEVEL_LO = 1;
  localparam int IU_LEVEL_HI = 2;

  // output sideband: accepted, dropped_full, granted, out_priority, work_pending
  localparam int OUT_USER_W  = 6;
  localparam int OU_ACCEPTED = 0;
  localparam int OU_DROPPED  = 1;
  localparam int OU_GRANTED  = 2;
  localparam int OU_LEVEL_LO = 3;
  localparam int OU_LEVEL_HI = 4;
  localparam int OU_PENDING  = 5;

endpackage

/* rtl/core/strict_priority_three_fifo_scheduler.sv */
// A result beat is registered and appears in the cycle after its input beat is taken.
// One submit or pick is taken per cycle; the tag memory is read or written
// once per beat and the pointer update plus level encode are combinational.
// The input is stalled only while a result waits and m_tready is low.
// Reset (rst, synchronous): all queues empty, no result pending; the tag
// memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// strict_priority_three_fifo_scheduler
// Three FIFO queues of job tags, one per level; a pick takes the head of the
// highest non-empty level, a submit to a full queue is dropped and flagged.
// ----------------------------------------------------------------------------
module strict_priority_three_fifo_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // job_tag
  input  logic [((TAG_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,
  // action, priority_req[1:0]
  input  logic [spfs_pkg::IN_USER_W-1:0]          s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // out_tag
  output logic [((TAG_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,
  // accepted, dropped_full, granted, out_priority[1:0], work_pending
  output logic [spfs_pkg::OUT_USER_W-1:0]         m_tuser
);

  localparam int DATA_W    = ((TAG_WIDTH + 7) / 8) * 8;
  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = spfs_pkg::LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // queue pointers and fill counts
  logic [IDX_W-1:0] head      [spfs_pkg::LEVELS];
  logic [IDX_W-1:0] head_next [spfs_pkg::LEVELS];
  logic [IDX_W-1:0] tail      [spfs_pkg::LEVELS];
  logic [IDX_W-1:0] tail_next [spfs_pkg::LEVELS];
  logic [CNT_W-1:0] fill      [spfs_pkg::LEVELS];
  logic [CNT_W-1:0] fill_next [spfs_pkg::LEVELS];

  // tag memory, one region per level
  logic [TAG_WIDTH-1:0] mem [MEM_DEPTH];
  logic [TAG_WIDTH-1:0] rd_data;

  // result register
  logic                 res_accepted;
  logic                 res_dropped;
  logic                 res_granted;
  logic                 res_use_mem;
  logic [TAG_WIDTH-1:0] res_tag;
  logic [1:0]           res_level;
  logic                 res_pending;

  logic                 accept;
  logic                 is_pick;
  logic [1:0]           raw_level;
  logic [1:0]           sub_level;
  logic                 sub_full;
  logic                 pick_hit;
  logic [1:0]           pick_level;
  logic                 wr_en;
  logic                 rd_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 pending_next;
  logic [TAG_WIDTH-1:0] in_tag;
  logic [TAG_WIDTH-1:0] out_tag;

  // advance a slot index with wrap at the queue depth
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) r = '0;
    else                              r = i + 1'b1;
    return r;
  endfunction

  // input beat handshake; a beat is taken whenever the result slot frees up
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // decode the beat
  assign is_pick   = (s_tuser[spfs_pkg::IU_ACTION] == spfs_pkg::ACT_PICK);
  assign raw_level = s_tuser[spfs_pkg::IU_LEVEL_HI:spfs_pkg::IU_LEVEL_LO];
  assign sub_level = (raw_level > spfs_pkg::LVL_LOW) ? spfs_pkg::LVL_LOW : raw_level;
  assign sub_full  = (fill[sub_level] == CNT_W'(QUEUE_DEPTH));
  assign in_tag    = s_tdata[TAG_WIDTH-1:0];

  // strict priority encode over the non-empty levels
  always_comb begin
    pick_hit   = 1'b1;
    pick_level = spfs_pkg::LVL_HIGH;
    priority if (fill[spfs_pkg::LVL_HIGH] != '0) begin
      pick_level = spfs_pkg::LVL_HIGH;
    end else if (fill[spfs_pkg::LVL_NORMAL] != '0) begin
      pick_level = spfs_pkg::LVL_NORMAL;
    end else if (fill[spfs_pkg::LVL_LOW] != '0) begin
      pick_level = spfs_pkg::LVL_LOW;
    end else begin
      pick_hit   = 1'b0;
    end
  end

  // memory port controls
  assign wr_en   = accept && !is_pick && !sub_full;
  assign rd_en   = accept && is_pick && pick_hit;
  assign wr_addr = ADDR_W'(sub_level) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail[sub_level]);
  assign rd_addr = ADDR_W'(pick_level) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[pick_level]);

  // pointer and count update
  always_comb begin
    for (int i = 0; i < spfs_pkg::LEVELS; i++) begin
      head_next[i] = head[i];
      tail_next[i] = tail[i];
      fill_next[i] = fill[i];
    end
    if (wr_en) begin
      tail_next[sub_level] = wrap_inc(tail[sub_level]);
      fill_next[sub_level] = fill[sub_level] + 1'b1;
    end
    if (rd_en) begin
      head_next[pick_level] = wrap_inc(head[pick_level]);
      fill_next[pick_level] = fill[pick_level] - 1'b1;
    end
  end

  assign pending_next = (fill_next[spfs_pkg::LVL_HIGH] != '0) ||
                        (fill_next[spfs_pkg::LVL_NORMAL] != '0) ||
                        (fill_next[spfs_pkg::LVL_LOW] != '0);

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spfs_pkg::LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      for (int i = 0; i < spfs_pkg::LEVELS; i++) begin
        head[i] <= head_next[i];
        tail[i] <= tail_next[i];
        fill[i] <= fill_next[i];
      end
    end
  end

  // tag memory: write at tail on submit, registered read at head on pick
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_tag;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result payload, loaded with each taken beat
  always_ff @(posedge clk) begin
    if (accept) begin
      res_accepted <= !is_pick && !sub_full;
      res_dropped  <= !is_pick && sub_full;
      res_granted  <= is_pick && pick_hit;
      res_use_mem  <= is_pick && pick_hit;
      res_tag      <= is_pick ? '0 : in_tag;
      res_level    <= is_pick ? (pick_hit ? pick_level : spfs_pkg::LVL_HIGH) : sub_level;
      res_pending  <= pending_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // output beat
  assign out_tag = res_use_mem ? rd_data : res_tag;
  assign m_tdata = DATA_W'(out_tag);

  always_comb begin
    m_tuser                                                = '0;
    m_tuser[spfs_pkg::OU_ACCEPTED]                         = res_accepted;
    m_tuser[spfs_pkg::OU_DROPPED]                          = res_dropped;
    m_tuser[spfs_pkg::OU_GRANTED]                          = res_granted;
    m_tuser[spfs_pkg::OU_LEVEL_HI:spfs_pkg::OU_LEVEL_LO]   = res_level;
    m_tuser[spfs_pkg::OU_PENDING]                          = res_pending;
  end

endmodule

/* rtl/core/spfs_checker.sv */
// ----------------------------------------------------------------------------
// spfs_checker
// Port-level checks on the priority scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spfs_checker #(
  parameter int TAG_WIDTH = 64
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    s_tvalid,
  input logic                                    s_tready,
  input logic                                    m_tvalid,
  input logic                                    m_tready,
  input logic [((TAG_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,
  input logic [spfs_pkg::OUT_USER_W-1:0]         m_tuser
);

  logic s_beat;
  logic m_beat;
  logic m_stall;
  logic m_pending;
  logic empty_pick;
  logic [spfs_pkg::OUT_USER_W + ((TAG_WIDTH + 7) / 8) * 8 - 1:0] m_word;

  assign s_beat     = s_tvalid && s_tready;
  assign m_beat     = m_tvalid && m_tready;
  assign m_stall    = m_tvalid && !m_tready;
  assign m_pending  = m_tuser[spfs_pkg::OU_PENDING];
  assign m_word     = {m_tuser, m_tdata};
  assign empty_pick = m_tvalid && !m_tuser[spfs_pkg::OU_GRANTED] &&
                      !m_tuser[spfs_pkg::OU_ACCEPTED] && !m_tuser[spfs_pkg::OU_DROPPED];

  // no result is held over reset
  `SPFS_ASSERT_NR(a_reset_clears, clk, rst |=> !m_tvalid)
  // a stalled result beat holds its payload
  `SPFS_ASSERT(a_stall_holds, clk, rst, m_stall |=> m_tvalid && $stable(m_word))
  // every taken input beat gives a result in the next cycle
  `SPFS_ASSERT(a_one_result, clk, rst, s_beat |=> m_tvalid)
  // a result taken with no new input leaves nothing behind
  `SPFS_ASSERT(a_no_phantom, clk, rst, m_beat && !s_beat |=> !m_tvalid)
  // a pick with no grant means every queue was empty
  `SPFS_ASSERT(a_empty_pick, clk, rst, empty_pick |-> !m_pending && (m_tdata == '0))

endmodule

bind strict_priority_three_fifo_scheduler spfs_checker #(
  .TAG_WIDTH (TAG_WIDTH)
) u_spfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
